[design/rde_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_pkg: shared types, constants and helpers for the radix digit emitter
// Holds field widths, register indexes, reset values, alphabet lookup and
// the alphabet validity check.
// ----------------------------------------------------------------------------
package rde_pkg;

   localparam int VALUE_W    = 64;
   localparam int RADIX_W    = 5;
   localparam int ALPHA_W    = 64;
   localparam int CHAR_W     = 8;
   localparam int DIGIT_W    = 4;
   localparam int MAX_RADIX  = 16;
   localparam int MAX_DIGITS = 64;
   localparam int IDX_W      = $clog2(MAX_DIGITS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int CSR_IDX_W  = 2;

   // Dividend bits consumed per divider cycle, and divider cycles per digit.
   localparam int DIV_BITS   = 8;
   localparam int DIV_CYCLES = VALUE_W / DIV_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

   localparam logic [CHAR_W-1:0]  CHAR_NUL   = 8'd0;
   localparam logic [CHAR_W-1:0]  CHAR_PLUS  = 8'd43;
   localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
   localparam logic [RADIX_W-1:0] RADIX_MIN  = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX  = 5'(MAX_RADIX);

   localparam logic [RADIX_W-1:0] RADIX_RESET    = 5'd10;
   localparam logic [ALPHA_W-1:0] ALPHA_LO_RESET = 64'd3978425819141910832;
   localparam logic [ALPHA_W-1:0] ALPHA_HI_RESET = 64'd14648;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIX    = 2'd0,
      CSR_ALPHA_LO = 2'd1,
      CSR_ALPHA_HI = 2'd2
   } csr_index_type;

   // Status from the divider back to the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   function automatic logic [CHAR_W-1:0] alpha_char(
      input logic [ALPHA_W-1:0] lo,
      input logic [ALPHA_W-1:0] hi,
      input logic [DIGIT_W-1:0] idx
   );
      logic [2:0] sel;
      sel = idx[2:0];
      if (idx[3]) begin
         return hi[sel*CHAR_W +: CHAR_W];
      end
      return lo[sel*CHAR_W +: CHAR_W];
   endfunction

   // Radix in range, and no sign, NUL or repeated character among the
   // characters in use.
   function automatic logic alphabet_ok(
      input logic [RADIX_W-1:0] radix,
      input logic [ALPHA_W-1:0] lo,
      input logic [ALPHA_W-1:0] hi
   );
      logic              ok;
      logic [CHAR_W-1:0] ci;
      ok = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
      for (int i = 0; i < MAX_RADIX; i++) begin
         ci = alpha_char(lo, hi, DIGIT_W'(i));
         if (RADIX_W'(i) < radix) begin
            if (ci == CHAR_NUL || ci == CHAR_PLUS || ci == CHAR_MINUS) begin
               ok = 1'b0;
            end
            for (int j = i + 1; j < MAX_RADIX; j++) begin
               if (RADIX_W'(j) < radix && alpha_char(lo, hi, DIGIT_W'(j)) == ci) begin
                  ok = 1'b0;
               end
            end
         end
      end
      return ok;
   endfunction

endpackage

[design/radix_digit_emitter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_emitter_core: unsigned 64-bit value to radix-N digit string
// Divides the value by the configured radix, stores the remainders, then
// emits the mapped digit characters most significant first.
// ----------------------------------------------------------------------------
// One value is taken per beat on the req channel; req_ready is high only
// while the block is idle. The value is divided by the radix repeatedly in
// one shared divider that retires eight dividend bits per cycle; after each
// divide the remainder is stored and the divider restarts on the quotient.
// The remainders land in a 64-entry digit store; they are then read back
// in reverse and sent as one rsp beat per digit, each beat held until the
// sink takes it (value zero gives one digit; radix 2 can give 64). When
// the radix is out of the 2..16 range, or the characters in use hold a
// '+', '-', a NUL byte or a repeat, the value yields no beats and the
// block returns to idle from the check state. The final beat of each value
// carries rsp_last. Registers are written through csr_*; the user must
// write them only while the block is idle, which the block itself does
// not enforce. An index beyond the register list is dropped.
// ----------------------------------------------------------------------------
module radix_digit_emitter_core
   import rde_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [VALUE_W-1:0]   req_value,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CHAR_W-1:0]    rsp_character,
   output logic                 rsp_last,

   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ALPHA_W-1:0]   csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_READ,
      ST_LOAD,
      ST_HOLD
   } state_type;

   state_type            state_ff, state_in;

   // Configuration registers.
   logic [RADIX_W-1:0]   radix_ff;
   logic [ALPHA_W-1:0]   alpha_lo_ff;
   logic [ALPHA_W-1:0]   alpha_hi_ff;

   // Sequencer state.
   logic [VALUE_W-1:0]   quotient_ff, quotient_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Divider and store hookup.
   logic                 div_start;
   logic [VALUE_W-1:0]   div_dividend;
   div_status_type       div_status;
   logic [VALUE_W-1:0]   div_quotient;
   logic [DIGIT_W-1:0]   div_remainder;
   logic                 store_wr_en;
   logic [DIGIT_W-1:0]   store_rd_data;
   logic                 more_digits;

   // ------------------------------------------------------------------
   // Configuration writes: decode the index, drop anything past the list.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff    <= RADIX_RESET;
         alpha_lo_ff <= ALPHA_LO_RESET;
         alpha_hi_ff <= ALPHA_HI_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_RADIX:    radix_ff    <= csr_wdata[RADIX_W-1:0];
            CSR_ALPHA_LO: alpha_lo_ff <= csr_wdata;
            CSR_ALPHA_HI: alpha_hi_ff <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // Keep dividing while the quotient is nonzero and the store has room.
   assign more_digits = (div_quotient != '0) &&
                        (count_ff != CNT_W'(MAX_DIGITS - 1));

   // ------------------------------------------------------------------
   // Sequencer: check alphabet, divide digit by digit, then emit.
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      quotient_in  = quotient_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      div_start    = 1'b0;
      div_dividend = div_quotient;
      store_wr_en  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               quotient_in = req_value;
               count_in    = '0;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // Bad alphabet: drop the value without a beat.
            if (alphabet_ok(radix_ff, alpha_lo_ff, alpha_hi_ff)) begin
               div_start    = 1'b1;
               div_dividend = quotient_ff;
               state_in     = ST_DIVIDE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               store_wr_en = 1'b1;
               quotient_in = div_quotient;
               count_in    = count_ff + 1'b1;
               if (more_digits) begin
                  div_start = 1'b1;
               end else begin
                  // Most significant digit sits at the last written slot.
                  idx_in   = count_ff[IDX_W-1:0];
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            // Store samples idx_ff at the end of this cycle.
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = alpha_char(alpha_lo_ff, alpha_hi_ff, store_rd_data);
            rsp_last_in  = (idx_ff == '0);
            state_in     = ST_HOLD;
         end
         ST_HOLD: begin
            // Hold the beat until taken, then advance to the next digit.
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff - 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         quotient_ff  <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         quotient_ff  <= quotient_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   rde_div_unit u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (radix_ff),
      .status    (div_status),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   rde_digit_store u_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (div_remainder),
      .rd_addr (idx_ff),
      .rd_data (store_rd_data)
   );

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

[design/rde_div_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_div_unit: shared iterative divider by a small radix
// Restoring division of a 64-bit value by a 5-bit divisor, eight quotient
// bits per cycle; quotient and remainder are valid while done is high.
// ----------------------------------------------------------------------------
module rde_div_unit
   import rde_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [VALUE_W-1:0]   dividend,
   input  logic [RADIX_W-1:0]   divisor,
   output div_status_type       status,
   output logic [VALUE_W-1:0]   quotient,
   output logic [DIGIT_W-1:0]   remainder
);

   logic [VALUE_W-1:0]   shift_ff, shift_in;
   logic [DIGIT_W-1:0]   rem_ff, rem_in;
   logic [RADIX_W-1:0]   divisor_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [RADIX_W-1:0]   part;

   // Eight dependent compare/subtract steps on a 5-bit partial remainder.
   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      part     = '0;
      for (int b = 0; b < DIV_BITS; b++) begin
         part     = {rem_in, shift_in[VALUE_W-1]};
         shift_in = {shift_in[VALUE_W-2:0], 1'b0};
         if (part >= divisor_ff) begin
            part        = part - divisor_ff;
            shift_in[0] = 1'b1;
         end
         rem_in = part[DIGIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            shift_ff   <= dividend;
            rem_ff     <= '0;
            divisor_ff <= divisor;
            cnt_ff     <= '0;
            busy_ff    <= 1'b1;
         end else if (busy_ff) begin
            shift_ff <= shift_in;
            rem_ff   <= rem_in;
            cnt_ff   <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = shift_ff;
   assign remainder   = rem_ff;

endmodule

[design/rde_digit_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_digit_store: remainder memory
// 64 x 4-bit store, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rde_digit_store
   import rde_pkg::*;
(
   input  logic               clock,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_addr,
   input  logic [DIGIT_W-1:0] wr_data,
   input  logic [IDX_W-1:0]   rd_addr,
   output logic [DIGIT_W-1:0] rd_data
);

   logic [DIGIT_W-1:0] mem [MAX_DIGITS];
   logic [DIGIT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/rde_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_checker: port-level checks for the radix digit emitter
// Watches the req and rsp channels for sequencing slips; bound to the core.
// ----------------------------------------------------------------------------
module rde_checker
   import rde_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic [VALUE_W-1:0]   req_value,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [CHAR_W-1:0]    rsp_character,
   input logic                 rsp_last,
   input logic                 csr_write_en,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [ALPHA_W-1:0]   csr_wdata
);

   // A stalled beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_character) && $stable(rsp_last))
      else $error("rsp beat changed while stalled");

   // An accepted value makes the block busy.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken again right after accept");

   // No new value while a digit beat is out.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("req ready while rsp beat pending");

   // The final beat closes the value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid)
      else $error("rsp beat after last");

   // More digits follow a non-final beat, so stay busy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> !req_ready)
      else $error("req ready in the middle of a digit string");

endmodule

bind radix_digit_emitter_core rde_checker u_rde_checker (.*);
